[rtl/dfrcm_pkg.sv]
// ----------------------------------------------------------------------------
// dfrcm_pkg: shared constants for the distance-field ridge/contour marker
// Field widths, register indexes and reset values used across the block.
// ----------------------------------------------------------------------------
package dfrcm_pkg;

  localparam int MAX_WIDTH_DEFAULT = 1024;
  localparam int FRAC_BITS_DEFAULT = 8;

  localparam int DIST_W   = 16;
  localparam int PIX_W    = DIST_W + 1;  // water bit on top of the distance
  localparam int COORD_W  = 10;
  localparam int LEVEL_W  = 16;
  localparam int IMG_W_W  = 11;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONTOUR_LEVEL = 1'b0,
    REG_IMAGE_WIDTH   = 1'b1
  } reg_idx_t;

  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 16'd1024;
  localparam logic [IMG_W_W-1:0] WIDTH_RESET = 11'd1024;

endpackage

[rtl/dfrcm_pix_if.sv]
// ----------------------------------------------------------------------------
// dfrcm_pix_if: input pixel channel
// One beat carries a distance sample and its water bit.
// ----------------------------------------------------------------------------
interface dfrcm_pix_if;
  logic                          valid;
  logic                          ready;
  logic [dfrcm_pkg::DIST_W-1:0]  distance;
  logic                          water;

  modport source (output valid, distance, water, input ready);
  modport sink   (input valid, distance, water, output ready);
endinterface

[rtl/dfrcm_res_if.sv]
// ----------------------------------------------------------------------------
// dfrcm_res_if: result channel
// One beat carries the classification of one pixel.
// ----------------------------------------------------------------------------
interface dfrcm_res_if;
  logic                          valid;
  logic                          ready;
  logic [dfrcm_pkg::COORD_W-1:0] col;
  logic [dfrcm_pkg::COORD_W-1:0] row_index;
  logic                          on_contour;
  logic                          on_ridge;
  logic                          last_of_run;
  logic                          image_done;

  modport source (output valid, col, row_index, on_contour, on_ridge, last_of_run,
                  image_done, input ready);
  modport sink   (input valid, col, row_index, on_contour, on_ridge, last_of_run,
                  image_done, output ready);
endinterface

[rtl/dfrcm_cfg_if.sv]
// ----------------------------------------------------------------------------
// dfrcm_cfg_if: configuration write channel
// One beat writes one register by index.
// ----------------------------------------------------------------------------
interface dfrcm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dfrcm_pkg::CFG_IDX_W-1:0]  index;
  logic [dfrcm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/dfrcm_line_store.sv]
// ----------------------------------------------------------------------------
// dfrcm_line_store: two line memories for the 3x3 window
// Reads the column of the upper and middle line on accept, writes the new
// pixel into the middle line and moves the old middle entry up later.
// ----------------------------------------------------------------------------
module dfrcm_line_store #(
  parameter int MAX_WIDTH = dfrcm_pkg::MAX_WIDTH_DEFAULT,
  parameter int AW        = $clog2(MAX_WIDTH)
) (
  input  logic                        clk,
  input  logic                        accept,
  input  logic [AW-1:0]               addr,
  input  logic [dfrcm_pkg::PIX_W-1:0] pix,
  input  logic                        advance,
  output logic [dfrcm_pkg::PIX_W-1:0] top,
  output logic [dfrcm_pkg::PIX_W-1:0] mid
);

  logic [dfrcm_pkg::PIX_W-1:0] upper_line  [MAX_WIDTH];
  logic [dfrcm_pkg::PIX_W-1:0] middle_line [MAX_WIDTH];
  logic [AW-1:0]               addr_q;

  // middle line: read old entry, write new pixel at the same column
  always_ff @(posedge clk) begin
    if (accept) begin
      mid              <= middle_line[addr];
      middle_line[addr] <= pix;
      addr_q           <= addr;
    end
  end

  // upper line: read on accept, old middle entry moves up when the beat leaves
  always_ff @(posedge clk) begin
    if (accept) begin
      top <= upper_line[addr];
    end
    if (advance) begin
      upper_line[addr_q] <= mid;
    end
  end

endmodule

[rtl/dfrcm_classify.sv]
// ----------------------------------------------------------------------------
// dfrcm_classify: contour and ridge test for one window position
// Mirrors neighbours at the image border and applies the level, local
// maximum and gradient alignment tests.
// ----------------------------------------------------------------------------
module dfrcm_classify #(
  parameter int AW        = 10,
  parameter int WW        = 11,
  parameter int FRAC_BITS = dfrcm_pkg::FRAC_BITS_DEFAULT
) (
  input  logic [dfrcm_pkg::PIX_W-1:0]   win [9],
  input  logic [1:0]                    tr,
  input  logic [1:0]                    tc,
  input  logic [AW-1:0]                 x,
  input  logic [AW-1:0]                 y,
  input  logic [WW-1:0]                 w,
  input  logic [dfrcm_pkg::LEVEL_W-1:0] level,
  output logic                          contour,
  output logic                          ridge
);

  localparam int PW = 38;
  localparam logic [PW-1:0] TINY = PW'(1) << (2 * FRAC_BITS);
  localparam logic [dfrcm_pkg::DIST_W-1:0] ONE = dfrcm_pkg::DIST_W'(1) << FRAC_BITS;

  logic [1:0] lc, rc, tp, bt;
  logic [dfrcm_pkg::DIST_W-1:0] d, lv, rv, tv, bv, tl, br, trv, bl;
  logic water;
  logic [3:0] m;
  logic signed [16:0] gx, gy;
  logic signed [17:0] s, t;
  logic signed [PW-1:0] gx2, gy2, s2, t2, g2;
  logic below, aligned;

  function automatic logic [3:0] idx(input logic [1:0] r, input logic [1:0] c);
    logic [1:0] rr, cc;
    rr = (r > 2'd2) ? 2'd2 : r;
    cc = (c > 2'd2) ? 2'd2 : c;
    idx = 4'(rr) * 4'd3 + 4'(cc);
  endfunction

  function automatic logic lmax(input logic [15:0] a, input logic [15:0] b,
                                input logic [15:0] v);
    lmax = (v >= a) && (v >= b) && ((v > a) || (v > b));
  endfunction

  // border mirroring
  always_comb begin
    lc = (x == '0) ? tc + 2'd1 : tc - 2'd1;
    rc = ({1'b0, x} >= w - WW'(1)) ? tc - 2'd1 : tc + 2'd1;
    tp = (y == '0) ? tr + 2'd1 : tr - 2'd1;
    bt = ({1'b0, y} >= w - WW'(1)) ? tr - 2'd1 : tr + 2'd1;
  end

  assign water = win[idx(tr, tc)][dfrcm_pkg::DIST_W];
  assign d   = win[idx(tr, tc)][dfrcm_pkg::DIST_W-1:0];
  assign lv  = win[idx(tr, lc)][dfrcm_pkg::DIST_W-1:0];
  assign rv  = win[idx(tr, rc)][dfrcm_pkg::DIST_W-1:0];
  assign tv  = win[idx(tp, tc)][dfrcm_pkg::DIST_W-1:0];
  assign bv  = win[idx(bt, tc)][dfrcm_pkg::DIST_W-1:0];
  assign tl  = win[idx(tp, lc)][dfrcm_pkg::DIST_W-1:0];
  assign br  = win[idx(bt, rc)][dfrcm_pkg::DIST_W-1:0];
  assign trv = win[idx(tp, rc)][dfrcm_pkg::DIST_W-1:0];
  assign bl  = win[idx(bt, lc)][dfrcm_pkg::DIST_W-1:0];

  // local maxima across the four neighbour pairs
  assign m[0] = lmax(lv, rv, d);
  assign m[1] = lmax(tv, bv, d);
  assign m[2] = lmax(tl, br, d);
  assign m[3] = lmax(trv, bl, d);

  // gradient squares
  assign gx  = $signed({1'b0, rv}) - $signed({1'b0, lv});
  assign gy  = $signed({1'b0, bv}) - $signed({1'b0, tv});
  assign s   = 18'(gx) + 18'(gy);
  assign t   = 18'(gx) - 18'(gy);
  assign gx2 = gx * gx;
  assign gy2 = gy * gy;
  assign s2  = s * s;
  assign t2  = t * t;
  assign g2  = gx2 + gy2;

  assign aligned = (m[0] && ((gx2 <<< 1) + gx2 >= gy2)) ||
                   (m[1] && ((gy2 <<< 1) + gy2 >= gx2)) ||
                   (m[2] && ((s2 <<< 1) >= g2)) ||
                   (m[3] && ((t2 <<< 1) >= g2));

  assign below = (lv < level) || (rv < level) || (tv < level) || (bv < level) ||
                 (tl < level) || (br < level) || (trv < level) || (bl < level);

  always_comb begin
    contour = 1'b0;
    ridge   = 1'b0;
    if (water) begin
      if (d >= level) begin
        contour = below;
      end else if (d > ONE && (m != 4'b0000)) begin
        ridge = ((g2 <<< 2) < $signed(TINY)) ? 1'b1 : aligned;
      end
    end
  end

endmodule

[rtl/distance_field_ridge_contour_marker.sv]
// ----------------------------------------------------------------------------
// distance_field_ridge_contour_marker: 3x3 streaming ridge/contour classifier
// Results pass stage 1, the stage 2 window and the output register. One pixel
// per cycle while the output is not stalled and each pixel yields at most one
// result; one yielding more holds the input until all are emitted (up to four
// at the image end). Reset clears counters, window and handshake state; line
// memories are not cleared, and entries read unwritten never reach a result.
// ----------------------------------------------------------------------------
module distance_field_ridge_contour_marker #(
  parameter int MAX_WIDTH = dfrcm_pkg::MAX_WIDTH_DEFAULT,
  parameter int FRAC_BITS = dfrcm_pkg::FRAC_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  dfrcm_pix_if.sink    pix_in,
  dfrcm_res_if.source  res_out,
  dfrcm_cfg_if.sink    cfg
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int PW = dfrcm_pkg::PIX_W;

  // configuration registers
  logic [dfrcm_pkg::LEVEL_W-1:0] contour_level;
  logic [dfrcm_pkg::IMG_W_W-1:0] image_width;
  logic [WW-1:0]                 w;
  logic [AW-1:0]                 w_last;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      contour_level <= dfrcm_pkg::LEVEL_RESET;
      image_width   <= dfrcm_pkg::WIDTH_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        dfrcm_pkg::REG_CONTOUR_LEVEL: contour_level <= cfg.data[dfrcm_pkg::LEVEL_W-1:0];
        dfrcm_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg.data[dfrcm_pkg::IMG_W_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the side to 2..MAX_WIDTH
  always_comb begin
    if (int'(image_width) < 2)              w = WW'(2);
    else if (int'(image_width) > MAX_WIDTH) w = WW'(MAX_WIDTH);
    else                                    w = WW'(image_width);
  end
  assign w_last = AW'(w - WW'(1));

  // raster counters
  logic [AW-1:0] in_col, in_row, c_in, r_in;
  logic          accept;

  assign c_in = ({1'b0, in_col} >= w) ? w_last : in_col;
  assign r_in = ({1'b0, in_row} >= w) ? w_last : in_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col <= '0;
      in_row <= '0;
    end else if (accept) begin
      if (c_in == w_last) begin
        in_col <= '0;
        in_row <= (r_in == w_last) ? '0 : r_in + AW'(1);
      end else begin
        in_col <= c_in + AW'(1);
      end
    end
  end

  // stage 1: memory read
  logic          s1_v, s1_move;
  logic [AW-1:0] s1_c, s1_r;
  logic [PW-1:0] s1_pix, top, mid;

  assign pix_in.ready = !s1_v || s1_move;
  assign accept       = pix_in.valid && pix_in.ready;

  dfrcm_line_store #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_lines (
    .clk     (clk),
    .accept  (accept),
    .addr    (c_in),
    .pix     ({pix_in.water, pix_in.distance}),
    .advance (s1_move),
    .top     (top),
    .mid     (mid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (accept) begin
      s1_v <= 1'b1;
    end else if (s1_move) begin
      s1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_c   <= c_in;
      s1_r   <= r_in;
      s1_pix <= {pix_in.water, pix_in.distance};
    end
  end

  // stage 2: window and result emitter
  logic [PW-1:0] window [9];
  logic [3:0]    mask, pick, mask_left, mask_new;
  logic [AW-1:0] s2_c, s2_r;
  logic          emit, fin, o_v;

  assign emit      = (mask != 4'b0) && (!o_v || res_out.ready);
  assign pick      = mask & (~mask + 4'd1);
  assign mask_left = mask & ~pick;
  assign fin       = emit && (mask_left == 4'b0);
  assign s1_move   = s1_v && ((mask == 4'b0) || fin);

  always_comb begin
    mask_new = 4'b0;
    if (s1_r != '0) begin
      mask_new[0] = (s1_c != '0);
      mask_new[1] = (s1_c == w_last);
      mask_new[2] = (s1_c != '0) && (s1_r == w_last);
      mask_new[3] = (s1_c == w_last) && (s1_r == w_last);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= 4'b0;
      for (int i = 0; i < 9; i++) window[i] <= '0;
    end else begin
      if (s1_move) begin
        mask <= mask_new;
        for (int i = 0; i < 3; i++) begin
          window[i*3]   <= window[i*3+1];
          window[i*3+1] <= window[i*3+2];
        end
        window[2] <= top;
        window[5] <= mid;
        window[8] <= s1_pix;
      end else if (emit) begin
        mask <= mask_left;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_c <= s1_c;
      s2_r <= s1_r;
    end
  end

  // position of the result being emitted
  logic [1:0]    tr, tc;
  logic [AW-1:0] x, y;

  always_comb begin
    tr = 2'd1;
    tc = 2'd1;
    x  = s2_c - AW'(1);
    y  = s2_r - AW'(1);
    case (pick)
      4'b0001: begin tr = 2'd1; tc = 2'd1; x = s2_c - AW'(1); y = s2_r - AW'(1); end
      4'b0010: begin tr = 2'd1; tc = 2'd2; x = w_last;        y = s2_r - AW'(1); end
      4'b0100: begin tr = 2'd2; tc = 2'd1; x = s2_c - AW'(1); y = s2_r;          end
      4'b1000: begin tr = 2'd2; tc = 2'd2; x = w_last;        y = s2_r;          end
      default: ;
    endcase
  end

  logic contour, ridge;

  dfrcm_classify #(.AW(AW), .WW(WW), .FRAC_BITS(FRAC_BITS)) u_classify (
    .win     (window),
    .tr      (tr),
    .tc      (tc),
    .x       (x),
    .y       (y),
    .w       (w),
    .level   (contour_level),
    .contour (contour),
    .ridge   (ridge)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (emit) begin
      o_v <= 1'b1;
    end else if (res_out.ready) begin
      o_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_out.col         <= dfrcm_pkg::COORD_W'(x);
      res_out.row_index   <= dfrcm_pkg::COORD_W'(y);
      res_out.on_contour  <= contour;
      res_out.on_ridge    <= ridge;
      res_out.last_of_run <= (mask_left == 4'b0);
      res_out.image_done  <= (x == w_last) && (y == w_last);
    end
  end

  assign res_out.valid = o_v;

endmodule

[tb/sv/distance_field_ridge_contour_marker_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_field_ridge_contour_marker_tb: self-checking bench for the marker
// Streams square distance-field images through the pixel channel. A cycle-free
// model of the line stores and the 3x3 window predicts every classified pixel.
// A monitor compares each result beat field by field, in order.
// ----------------------------------------------------------------------------
module distance_field_ridge_contour_marker_tb;
  import dfrcm_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int MAXW           = MAX_WIDTH_DEFAULT;
  localparam int WIDE_PIXELS    = 48;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row_index;
    logic               on_contour;
    logic               on_ridge;
    logic               last_of_run;
    logic               image_done;
  } marker_t;

  logic clk;
  logic rst;

  dfrcm_pix_if pix ();
  dfrcm_res_if res ();
  dfrcm_cfg_if cfg ();

  distance_field_ridge_contour_marker dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix),
    .res_out (res),
    .cfg     (cfg)
  );

  // Shadow state of the classifier
  logic [PIX_W-1:0]   upper_mem [MAXW];
  logic [PIX_W-1:0]   middle_mem [MAXW];
  logic [PIX_W-1:0]   win [9];
  int unsigned        col_cnt;
  int unsigned        row_cnt;
  logic [LEVEL_W-1:0] level_reg;
  logic [IMG_W_W-1:0] width_reg;

  marker_t pending_marks [$];
  int      err_cnt;
  int      idle_cycles;
  bit      no_gaps;

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (no_gaps || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [PIX_W-1:0] win_at(int unsigned wr, int unsigned wc);
    if (wr > 2) wr = 2;
    if (wc > 2) wc = 2;
    return win[wr * 3 + wc];
  endfunction

  function automatic logic [DIST_W-1:0] dist_at(int unsigned wr, int unsigned wc);
    logic [PIX_W-1:0] p;
    p = win_at(wr, wc);
    return p[DIST_W-1:0];
  endfunction

  function automatic bit peak_across(longint d, longint a, longint b);
    return d >= a && d >= b && (d > a || d > b);
  endfunction

  // Expected result beats, in order
  function automatic void enqueue_mark(marker_t m);
    pending_marks.insert(pending_marks.size(), m);
  endfunction

  // Returns {on_contour, on_ridge} for the window cell (tr, tc)
  function automatic logic [1:0] classify(int unsigned tr, int unsigned tc,
                                          int unsigned x, int unsigned y, int unsigned w);
    int unsigned      lc, rc, tp, bt;
    logic [PIX_W-1:0] self_px;
    longint           d, lv, rv, tv, bv, tl, br, trv, bl, lev, gx, gy, g2, s, t;
    bit               m0, m1, m2, m3;
    lc = (x == 0) ? tc + 1 : tc - 1;
    rc = (x >= w - 1) ? tc - 1 : tc + 1;
    tp = (y == 0) ? tr + 1 : tr - 1;
    bt = (y >= w - 1) ? tr - 1 : tr + 1;
    self_px = win_at(tr, tc);
    d   = self_px[DIST_W-1:0];
    lv  = dist_at(tr, lc);
    rv  = dist_at(tr, rc);
    tv  = dist_at(tp, tc);
    bv  = dist_at(bt, tc);
    tl  = dist_at(tp, lc);
    br  = dist_at(bt, rc);
    trv = dist_at(tp, rc);
    bl  = dist_at(bt, lc);
    lev = level_reg;
    if (!self_px[DIST_W]) return 2'b00;
    if (d >= lev) begin
      if (lv < lev || rv < lev || tv < lev || bv < lev ||
          tl < lev || br < lev || trv < lev || bl < lev) return 2'b10;
      return 2'b00;
    end
    if (d <= (64'sd1 << FRAC_BITS_DEFAULT)) return 2'b00;
    m0 = peak_across(d, lv, rv);
    m1 = peak_across(d, tv, bv);
    m2 = peak_across(d, tl, br);
    m3 = peak_across(d, trv, bl);
    if (!(m0 || m1 || m2 || m3)) return 2'b00;
    gx = rv - lv;
    gy = bv - tv;
    g2 = gx * gx + gy * gy;
    // tiny gradient: |g| < 0.5 pixel
    if (4 * g2 < (64'sd1 << (2 * FRAC_BITS_DEFAULT))) return 2'b01;
    s = gx + gy;
    t = gx - gy;
    if ((m0 && 3 * gx * gx >= gy * gy) || (m1 && 3 * gy * gy >= gx * gx) ||
        (m2 && 2 * s * s >= g2) || (m3 && 2 * t * t >= g2)) return 2'b01;
    return 2'b00;
  endfunction

  // Advance the shadow window by one accepted pixel and queue its results
  function automatic void predict_markers(logic [DIST_W-1:0] dist_val, logic wet);
    int unsigned      w, c, r, n;
    int unsigned      er [4], ec [4], ex [4], ey [4];
    logic [PIX_W-1:0] top_px, mid_px, new_px;
    logic [1:0]       cls;
    marker_t          m;
    w = width_reg;
    if (w < 2) w = 2;
    if (w > MAXW) w = MAXW;
    c = (col_cnt >= w) ? w - 1 : col_cnt;
    r = (row_cnt >= w) ? w - 1 : row_cnt;
    new_px = {wet, dist_val};
    top_px = upper_mem[c];
    mid_px = middle_mem[c];
    upper_mem[c]  = mid_px;
    middle_mem[c] = new_px;
    for (int i = 0; i < 3; i++) begin
      win[i * 3]     = win[i * 3 + 1];
      win[i * 3 + 1] = win[i * 3 + 2];
    end
    win[2] = top_px;
    win[5] = mid_px;
    win[8] = new_px;
    n = 0;
    if (r >= 1) begin
      if (c >= 1) begin er[n] = 1; ec[n] = 1; ex[n] = c - 1; ey[n] = r - 1; n++; end
      if (c == w - 1) begin er[n] = 1; ec[n] = 2; ex[n] = w - 1; ey[n] = r - 1; n++; end
      if (r == w - 1) begin
        if (c >= 1) begin er[n] = 2; ec[n] = 1; ex[n] = c - 1; ey[n] = r; n++; end
        if (c == w - 1) begin er[n] = 2; ec[n] = 2; ex[n] = w - 1; ey[n] = r; n++; end
      end
    end
    for (int k = 0; k < n; k++) begin
      cls = classify(er[k], ec[k], ex[k], ey[k], w);
      m.col         = ex[k][COORD_W-1:0];
      m.row_index   = ey[k][COORD_W-1:0];
      m.on_contour  = cls[1];
      m.on_ridge    = cls[0];
      m.last_of_run = (k == n - 1);
      m.image_done  = (ex[k] == w - 1 && ey[k] == w - 1);
      enqueue_mark(m);
    end
    if (c == w - 1) begin
      col_cnt = 0;
      row_cnt = (r == w - 1) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
      row_cnt = r;
    end
  endfunction

  // One pixel beat, with a random gap in front
  task automatic send_pixel(logic [DIST_W-1:0] dist_val, logic wet);
    int n;
    n = pick_gap();
    if (n > 0) begin
      @(negedge clk);
      pix.valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    pix.valid    = 1'b1;
    pix.distance = dist_val;
    pix.water    = wet;
    do @(posedge clk); while (!pix.ready);
    predict_markers(dist_val, wet);
  endtask

  task automatic end_pixels();
    @(negedge clk);
    pix.valid = 1'b0;
  endtask

  // Register write once the block has drained
  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    end_pixels();
    wait (pending_marks.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = value;
    do @(posedge clk); while (!cfg.ready);
    if (idx == REG_CONTOUR_LEVEL) level_reg = value;
    else width_reg = value[IMG_W_W-1:0];
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  function automatic int eff_width();
    if (width_reg < 2) return 2;
    if (width_reg > MAXW) return MAXW;
    return width_reg;
  endfunction

  // Directed: clamped small width, contour edges, ridge shapes, 1.0 and level ties
  task automatic test_directed();
    logic [DIST_W-1:0] d3 [9];
    logic              w3 [9];
    write_reg(REG_IMAGE_WIDTH, 16'd0);
    write_reg(REG_CONTOUR_LEVEL, 16'h0180);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'h0180, 1'b1);
    send_pixel(16'h0100, 1'b0);
    // 3x3: column ridge with flat gradient, non-water and exactly-1.0 cells
    write_reg(REG_IMAGE_WIDTH, 16'd3);
    write_reg(REG_CONTOUR_LEVEL, 16'hFFFF);
    d3 = '{16'h0100, 16'h0300, 16'h0100, 16'h0101, 16'h0300, 16'h0100,
           16'h0100, 16'h0300, 16'h0101};
    w3 = '{1, 1, 1, 1, 1, 0, 1, 1, 1};
    for (int i = 0; i < 9; i++) send_pixel(d3[i], w3[i]);
    // 3x3: contour ring around a raised center, cells at the level and a zero corner
    write_reg(REG_CONTOUR_LEVEL, 16'h0200);
    d3 = '{16'h0000, 16'h01FF, 16'h0200, 16'h0250, 16'h0400, 16'h0300,
           16'h0200, 16'h0900, 16'h0180};
    for (int i = 0; i < 9; i++) send_pixel(d3[i], 1'b1);
    end_pixels();
  endtask

  // Widest setting: part of a row, then shrink the width so the column
  // counter sits past the new side and closes the row
  task automatic test_wide_row();
    write_reg(REG_IMAGE_WIDTH, 16'd2047);
    write_reg(REG_CONTOUR_LEVEL, 16'h0000);
    no_gaps = 1'b1;
    for (int i = 0; i < WIDE_PIXELS; i++)
      send_pixel(16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)));
    no_gaps = 1'b0;
    write_reg(REG_IMAGE_WIDTH, 16'd2);
    write_reg(REG_CONTOUR_LEVEL, 16'h0300);
    send_pixel(16'h0280, 1'b1);
    send_pixel(16'h0400, 1'b1);
    send_pixel(16'h0200, 1'b1);
    end_pixels();
  endtask

  // Random images: mostly shaped distance fields, some pure noise
  task automatic test_random_images();
    int    sent, w, peak, slope, mid, shape, dv, pause_at;
    bit    paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < 150) begin
      case ($urandom_range(0, 5))
        0: write_reg(REG_CONTOUR_LEVEL, 16'h0000);
        1: write_reg(REG_CONTOUR_LEVEL, 16'hFFFF);
        default: write_reg(REG_CONTOUR_LEVEL, 16'($urandom_range(16'h0100, 16'h0C00)));
      endcase
      write_reg(REG_IMAGE_WIDTH, 16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1)
                                                                 : $urandom_range(2, 8)));
      w        = eff_width();
      shape    = $urandom_range(0, 9);
      peak     = $urandom_range(16'h0200, 16'h0A00);
      slope    = $urandom_range(16'h0010, 16'h0180);
      mid      = $urandom_range(0, w - 1);
      no_gaps  = ($urandom_range(0, 3) == 0);
      pause_at = (!paused && w > 3) ? $urandom_range(1, w * w - 1) : -1;
      for (int r = 0; r < w; r++) begin
        for (int c = 0; c < w; c++) begin
          if (r * w + c == pause_at) begin
            end_pixels();
            wait (pending_marks.size() == 0);
            paused = 1'b1;
          end
          if (shape < 3) dv = $urandom_range(0, 16'hFFFF);
          else begin
            dv = peak - slope * ((shape < 7) ? ((c > mid) ? c - mid : mid - c)
                                             : ((r > mid) ? r - mid : mid - r));
            dv = dv + $urandom_range(0, 16'h0020) - 16'h0010;
            if (dv < 0) dv = 0;
          end
          send_pixel(dv[DIST_W-1:0], $urandom_range(0, 9) != 0);
          sent++;
        end
      end
      no_gaps = 1'b0;
    end
    end_pixels();
  endtask

  // Result sink with random stalls
  initial begin
    int n;
    res.ready = 1'b0;
    @(negedge rst);
    forever begin
      n = pick_gap();
      @(negedge clk);
      res.ready = (n == 0);
      if (n > 0) repeat (n - 1) @(negedge clk);
      if (n > 0) begin
        @(negedge clk);
        res.ready = 1'b1;
      end
      repeat ($urandom_range(0, 8)) @(negedge clk);
    end
  end

  // Result checker
  always @(posedge clk) begin
    marker_t got, want;
    if (!rst && res.valid && res.ready) begin
      got = '{res.col, res.row_index, res.on_contour, res.on_ridge,
              res.last_of_run, res.image_done};
      if (pending_marks.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected result beat: col=%0d row=%0d", got.col, got.row_index);
      end else begin
        want = pending_marks.pop_front();
        if (got !== want) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("mismatch: exp col=%0d row=%0d con=%b rdg=%b last=%b done=%b",
                     want.col, want.row_index, want.on_contour, want.on_ridge,
                     want.last_of_run, want.image_done);
            $display("          got col=%0d row=%0d con=%b rdg=%b last=%b done=%b",
                     got.col, got.row_index, got.on_contour, got.on_ridge,
                     got.last_of_run, got.image_done);
          end
        end
      end
    end
  end

  // Watchdog: cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (res.valid && res.ready) ||
        (cfg.valid && cfg.ready)) idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    rst          = 1'b1;
    pix.valid    = 1'b0;
    pix.distance = '0;
    pix.water    = 1'b0;
    cfg.valid    = 1'b0;
    cfg.index    = REG_CONTOUR_LEVEL;
    cfg.data     = '0;
    err_cnt      = 0;
    idle_cycles  = 0;
    no_gaps      = 1'b0;
    col_cnt      = 0;
    row_cnt      = 0;
    level_reg    = LEVEL_RESET;
    width_reg    = WIDTH_RESET;
    for (int i = 0; i < 9; i++) win[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_wide_row();
    test_random_images();

    wait (pending_marks.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
rtl/dfrcm_pkg.sv
rtl/dfrcm_pix_if.sv
rtl/dfrcm_res_if.sv
rtl/dfrcm_cfg_if.sv
rtl/dfrcm_line_store.sv
rtl/dfrcm_classify.sv
rtl/distance_field_ridge_contour_marker.sv
tb/sv/distance_field_ridge_contour_marker_tb.sv
